// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the RTL. Simulation builds get the checks;
// synthesis builds see empty macro bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, ignored while reset is asserted
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Expression that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/core/rvc_pkg.sv =====
package rvc_pkg;

  localparam int unsigned CInstrW = 16;
  localparam int unsigned InstrW  = 32;

  // Quadrants (bits 1:0 of the compressed word)
  localparam logic [1:0] QUAD_0 = 2'b00;
  localparam logic [1:0] QUAD_1 = 2'b01;
  localparam logic [1:0] QUAD_2 = 2'b10;

  // Compressed funct3, quadrant 0
  localparam logic [2:0] C0_ADDI4SPN = 3'b000;
  localparam logic [2:0] C0_LW       = 3'b010;
  localparam logic [2:0] C0_SW       = 3'b110;

  // Compressed funct3, quadrant 1
  localparam logic [2:0] C1_ADDI  = 3'b000;
  localparam logic [2:0] C1_JAL   = 3'b001;
  localparam logic [2:0] C1_LI    = 3'b010;
  localparam logic [2:0] C1_LUI   = 3'b011;
  localparam logic [2:0] C1_MISC  = 3'b100;
  localparam logic [2:0] C1_J     = 3'b101;
  localparam logic [2:0] C1_BEQZ  = 3'b110;
  localparam logic [2:0] C1_BNEZ  = 3'b111;

  // Quadrant 1 MISC-ALU sub-ops (bits 11:10) and reg-reg ops (bits 6:5)
  localparam logic [1:0] MISC_SRLI = 2'b00;
  localparam logic [1:0] MISC_SRAI = 2'b01;
  localparam logic [1:0] MISC_ANDI = 2'b10;
  localparam logic [1:0] MISC_RR   = 2'b11;
  localparam logic [1:0] RR_SUB    = 2'b00;
  localparam logic [1:0] RR_XOR    = 2'b01;
  localparam logic [1:0] RR_OR     = 2'b10;
  localparam logic [1:0] RR_AND    = 2'b11;

  // Compressed funct3, quadrant 2
  localparam logic [2:0] C2_SLLI = 3'b000;
  localparam logic [2:0] C2_LWSP = 3'b010;
  localparam logic [2:0] C2_JRMV = 3'b100;
  localparam logic [2:0] C2_SWSP = 3'b110;

  // RV32I major opcodes
  localparam logic [6:0] OP_IMM   = 7'b0010011;
  localparam logic [6:0] OP_REG   = 7'b0110011;
  localparam logic [6:0] OP_JAL   = 7'b1101111;
  localparam logic [6:0] OP_BR    = 7'b1100011;
  localparam logic [6:0] OP_LOAD  = 7'b0000011;
  localparam logic [6:0] OP_STORE = 7'b0100011;
  localparam logic [6:0] OP_JALR  = 7'b1100111;
  localparam logic [6:0] OP_SYS   = 7'b1110011;
  localparam logic [6:0] OP_LUI   = 7'b0110111;

  // RV32I funct3 / funct7
  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLL  = 3'b001;
  localparam logic [2:0] F3_WORD = 3'b010;
  localparam logic [2:0] F3_XOR  = 3'b100;
  localparam logic [2:0] F3_SR   = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;
  localparam logic [2:0] F3_BEQ  = 3'b000;
  localparam logic [2:0] F3_BNE  = 3'b001;
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // Architectural registers with fixed roles
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_SP   = 5'd2;

  localparam logic [InstrW-1:0] NOP_WORD     = 32'h0000_0013;
  localparam logic [InstrW-1:0] ILLEGAL_WORD = 32'h0000_0000;
  localparam logic [11:0]       EBREAK_IMM   = 12'd1;

  // Decoder result
  typedef struct packed {
    logic [InstrW-1:0] word;
    logic              illegal;
  } rvc_result_t;

endpackage

// ===== rtl/core/rvc_expand.sv =====
// Combinational RV32C to RV32I expansion
module rvc_expand (
  input  logic [rvc_pkg::CInstrW-1:0] cword_i,
  output rvc_pkg::rvc_result_t        result_o
);

  logic [1:0]  quad;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [4:0]  rs2;
  logic [4:0]  rdp;
  logic [4:0]  rs1p;
  logic        b12;
  logic [11:0] imm6;
  logic        imm6_zero;
  logic [9:0]  joff;
  logic [6:0]  memoff;
  logic [31:0] word;

  // Common fields
  assign quad      = cword_i[1:0];
  assign f3        = cword_i[15:13];
  assign rd        = cword_i[11:7];
  assign rs2       = cword_i[6:2];
  assign rdp       = {2'b01, cword_i[4:2]};
  assign rs1p      = {2'b01, cword_i[9:7]};
  assign b12       = cword_i[12];
  assign imm6      = {{6{b12}}, b12, cword_i[6:2]};
  assign imm6_zero = !b12 && (rs2 == 5'd0);
  // Jump offset bits 10:1
  assign joff      = {cword_i[8], cword_i[10:9], cword_i[6], cword_i[7], cword_i[2],
                      cword_i[11], cword_i[5:3]};
  // LW/SW offset bits 6:0
  assign memoff    = {cword_i[5], cword_i[12:10], cword_i[6], 2'b00};

  // Expansion mux
  always_comb begin
    word = rvc_pkg::ILLEGAL_WORD;
    case (quad)
      rvc_pkg::QUAD_0: begin
        case (f3)
          rvc_pkg::C0_ADDI4SPN: begin
            if (cword_i[12:5] != 8'd0) begin
              word = {2'b00, cword_i[10:7], cword_i[12:11], cword_i[5], cword_i[6], 2'b00,
                      rvc_pkg::REG_SP, rvc_pkg::F3_ADD, rdp, rvc_pkg::OP_IMM};
            end
          end
          rvc_pkg::C0_LW: begin
            word = {5'd0, memoff, rs1p, rvc_pkg::F3_WORD, rdp, rvc_pkg::OP_LOAD};
          end
          rvc_pkg::C0_SW: begin
            word = {5'd0, memoff[6:5], rdp, rs1p, rvc_pkg::F3_WORD, memoff[4:0],
                    rvc_pkg::OP_STORE};
          end
          default: word = rvc_pkg::ILLEGAL_WORD;
        endcase
      end
      rvc_pkg::QUAD_1: begin
        case (f3)
          rvc_pkg::C1_ADDI: begin
            if (rd == rvc_pkg::REG_ZERO || imm6_zero) begin
              word = rvc_pkg::NOP_WORD;
            end else begin
              word = {imm6, rd, rvc_pkg::F3_ADD, rd, rvc_pkg::OP_IMM};
            end
          end
          rvc_pkg::C1_JAL: begin
            word = {b12, joff, b12, {8{b12}}, rvc_pkg::REG_RA, rvc_pkg::OP_JAL};
          end
          rvc_pkg::C1_LI: begin
            if (rd == rvc_pkg::REG_ZERO) begin
              word = rvc_pkg::NOP_WORD;
            end else begin
              word = {imm6, rvc_pkg::REG_ZERO, rvc_pkg::F3_ADD, rd, rvc_pkg::OP_IMM};
            end
          end
          rvc_pkg::C1_LUI: begin
            if (imm6_zero) begin
              word = rvc_pkg::ILLEGAL_WORD;
            end else if (rd == rvc_pkg::REG_SP) begin
              // ADDI16SP
              word = {{3{b12}}, cword_i[4:3], cword_i[5], cword_i[2], cword_i[6], 4'd0,
                      rvc_pkg::REG_SP, rvc_pkg::F3_ADD, rvc_pkg::REG_SP, rvc_pkg::OP_IMM};
            end else if (rd == rvc_pkg::REG_ZERO) begin
              word = rvc_pkg::NOP_WORD;
            end else begin
              word = {{15{b12}}, rs2, rd, rvc_pkg::OP_LUI};
            end
          end
          rvc_pkg::C1_MISC: begin
            case (cword_i[11:10])
              rvc_pkg::MISC_SRLI, rvc_pkg::MISC_SRAI: begin
                if (!b12 && rs2 != 5'd0) begin
                  word = {(cword_i[10] ? rvc_pkg::F7_ALT : rvc_pkg::F7_BASE), rs2, rs1p,
                          rvc_pkg::F3_SR, rs1p, rvc_pkg::OP_IMM};
                end
              end
              rvc_pkg::MISC_ANDI: begin
                word = {imm6, rs1p, rvc_pkg::F3_AND, rs1p, rvc_pkg::OP_IMM};
              end
              default: begin
                // Register-register group; bit 12 set is the reserved W space
                if (b12) begin
                  word = rvc_pkg::NOP_WORD;
                end else begin
                  case (cword_i[6:5])
                    rvc_pkg::RR_SUB: word = {rvc_pkg::F7_ALT, rdp, rs1p, rvc_pkg::F3_ADD,
                                             rs1p, rvc_pkg::OP_REG};
                    rvc_pkg::RR_XOR: word = {rvc_pkg::F7_BASE, rdp, rs1p, rvc_pkg::F3_XOR,
                                             rs1p, rvc_pkg::OP_REG};
                    rvc_pkg::RR_OR:  word = {rvc_pkg::F7_BASE, rdp, rs1p, rvc_pkg::F3_OR,
                                             rs1p, rvc_pkg::OP_REG};
                    default:         word = {rvc_pkg::F7_BASE, rdp, rs1p, rvc_pkg::F3_AND,
                                             rs1p, rvc_pkg::OP_REG};
                  endcase
                end
              end
            endcase
          end
          rvc_pkg::C1_J: begin
            word = {b12, joff, b12, {8{b12}}, rvc_pkg::REG_ZERO, rvc_pkg::OP_JAL};
          end
          rvc_pkg::C1_BEQZ: begin
            word = {{4{b12}}, cword_i[6:5], cword_i[2], rvc_pkg::REG_ZERO, rs1p,
                    rvc_pkg::F3_BEQ, cword_i[11:10], cword_i[4:3], b12, rvc_pkg::OP_BR};
          end
          default: begin
            word = {{4{b12}}, cword_i[6:5], cword_i[2], rvc_pkg::REG_ZERO, rs1p,
                    rvc_pkg::F3_BNE, cword_i[11:10], cword_i[4:3], b12, rvc_pkg::OP_BR};
          end
        endcase
      end
      rvc_pkg::QUAD_2: begin
        case (f3)
          rvc_pkg::C2_SLLI: begin
            if (b12 || rs2 == 5'd0) begin
              word = rvc_pkg::ILLEGAL_WORD;
            end else if (rd == rvc_pkg::REG_ZERO) begin
              word = rvc_pkg::NOP_WORD;
            end else begin
              word = {rvc_pkg::F7_BASE, rs2, rd, rvc_pkg::F3_SLL, rd, rvc_pkg::OP_IMM};
            end
          end
          rvc_pkg::C2_LWSP: begin
            if (rd != rvc_pkg::REG_ZERO) begin
              word = {4'd0, cword_i[3:2], b12, cword_i[6:4], 2'b00, rvc_pkg::REG_SP,
                      rvc_pkg::F3_WORD, rd, rvc_pkg::OP_LOAD};
            end
          end
          rvc_pkg::C2_JRMV: begin
            if (!b12) begin
              if (rs2 == 5'd0) begin
                // JR
                if (rd != rvc_pkg::REG_ZERO) begin
                  word = {12'd0, rd, rvc_pkg::F3_ADD, rvc_pkg::REG_ZERO, rvc_pkg::OP_JALR};
                end
              end else if (rd == rvc_pkg::REG_ZERO) begin
                word = rvc_pkg::NOP_WORD;
              end else begin
                // MV
                word = {rvc_pkg::F7_BASE, rs2, rvc_pkg::REG_ZERO, rvc_pkg::F3_ADD, rd,
                        rvc_pkg::OP_REG};
              end
            end else begin
              if (rd == rvc_pkg::REG_ZERO && rs2 == 5'd0) begin
                word = {rvc_pkg::EBREAK_IMM, rvc_pkg::REG_ZERO, rvc_pkg::F3_ADD,
                        rvc_pkg::REG_ZERO, rvc_pkg::OP_SYS};
              end else if (rs2 == 5'd0) begin
                // JALR
                word = {12'd0, rd, rvc_pkg::F3_ADD, rvc_pkg::REG_RA, rvc_pkg::OP_JALR};
              end else if (rd == rvc_pkg::REG_ZERO) begin
                word = rvc_pkg::NOP_WORD;
              end else begin
                // ADD
                word = {rvc_pkg::F7_BASE, rs2, rd, rvc_pkg::F3_ADD, rd, rvc_pkg::OP_REG};
              end
            end
          end
          rvc_pkg::C2_SWSP: begin
            word = {4'd0, cword_i[8:7], b12, rs2, rvc_pkg::REG_SP, rvc_pkg::F3_WORD,
                    cword_i[11:9], 2'b00, rvc_pkg::OP_STORE};
          end
          default: word = rvc_pkg::ILLEGAL_WORD;
        endcase
      end
      default: word = rvc_pkg::ILLEGAL_WORD;
    endcase
  end

  assign result_o.word    = word;
  assign result_o.illegal = (word == rvc_pkg::ILLEGAL_WORD);

endmodule

// ===== rtl/core/rv32c_decompressor.sv =====
// RV32C instruction expander. Each input beat carries one 16-bit compressed
// instruction; the matching output beat carries the 32-bit RV32I word and a
// flag that is set when that word is zero (illegal or unmapped encoding);
// rd = 0 hints, a zero C.ADDI immediate and the reserved W group come out as
// the NOP word 0x00000013. Words pass an input register, then a result
// register, and one instruction is taken every cycle while the output side
// keeps up; the decode between them is combinational field muxing. Output
// backpressure stalls both registers; each stage refills in the same cycle it drains.
`include "assert_macros.svh"

module rv32c_decompressor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rvc_pkg::CInstrW-1:0] compressed_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rvc_pkg::InstrW-1:0]  expanded_word_o,
  output logic                        illegal_flag_o
);

  logic                        s1_valid_q;
  logic                        s1_valid_d;
  logic [rvc_pkg::CInstrW-1:0] cword_q;
  logic                        s1_ready;
  logic                        s2_valid_q;
  logic                        s2_valid_d;
  logic                        s2_ready;
  rvc_pkg::rvc_result_t        dec_result;
  rvc_pkg::rvc_result_t        res_q;

  // Stage readiness: a stage takes a beat when empty or draining
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign s1_valid_d = s1_ready ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      cword_q <= compressed_word_i;
    end
  end

  rvc_expand u_expand (
    .cword_i  (cword_q),
    .result_o (dec_result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      res_q <= dec_result;
    end
  end

  assign out_valid_o     = s2_valid_q;
  assign expanded_word_o = res_q.word;
  assign illegal_flag_o  = res_q.illegal;

  // Checks
  `ASSERT_PROP(a_in_fills_s1, clk_i, rst_ni, in_valid_i && in_ready_o |=> s1_valid_q)
  `ASSERT_PROP(a_s1_moves_out, clk_i, rst_ni, s1_valid_q && s2_ready |=> out_valid_o)
  `ASSERT_PROP(a_stall_holds_s1, clk_i, rst_ni,
               s1_valid_q && !s2_ready |=> s1_valid_q && $stable(cword_q))
  `ASSERT_ALWAYS(a_flag_matches, clk_i, rst_ni,
                 !out_valid_o || (illegal_flag_o == (expanded_word_o == rvc_pkg::ILLEGAL_WORD)))

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RandomWords = 1400;
  localparam int unsigned TailWords   = 150;   // final stretch with no gaps or stalls
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned LongHold    = 200;

  logic                        clk_i             = 1'b0;
  logic                        rst_ni            = 1'b0;
  logic                        in_valid_i        = 1'b0;
  logic                        in_ready_o;
  logic [rvc_pkg::CInstrW-1:0] compressed_word_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i       = 1'b0;
  logic [rvc_pkg::InstrW-1:0]  expanded_word_o;
  logic                        illegal_flag_o;

  // Words waiting to be sent, and expansions waiting to come out
  logic [rvc_pkg::CInstrW-1:0] fetch_words[$];
  rvc_pkg::rvc_result_t        pending_expansions[$];

  int unsigned words_sent         = 0;
  int unsigned expansions_checked = 0;
  int unsigned mismatch_count     = 0;
  int unsigned illegal_count      = 0;
  int unsigned nop_count          = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned cycle_count        = 0;
  int unsigned n_directed         = 0;
  logic        quiet_tail         = 1'b0;

  rv32c_decompressor DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .compressed_word_i (compressed_word_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .expanded_word_o   (expanded_word_o),
    .illegal_flag_o    (illegal_flag_o)
  );

  always #5 clk_i = ~clk_i;

  // RV32I instruction formats
  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [6:0] op);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rvc_pkg::OP_JAL};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs1, logic [2:0] f3);
    return {imm[12], imm[10:5], rvc_pkg::REG_ZERO, rs1, f3, imm[4:1], imm[11],
            rvc_pkg::OP_BR};
  endfunction

  // Expected 32-bit expansion of one compressed word
  function automatic logic [31:0] expand_rvc(logic [15:0] c);
    logic [2:0]  f3;
    logic [4:0]  rd, rs2, rdp, rs1p;
    logic [11:0] imm6, ldst_off, spn_imm, sp16_imm, lwsp_off, swsp_off;
    logic [20:0] joff;
    logic [12:0] boff;
    logic [31:0] res;
    f3       = c[15:13];
    rd       = c[11:7];
    rs2      = c[6:2];
    rdp      = {2'b01, c[4:2]};
    rs1p     = {2'b01, c[9:7]};
    imm6     = {{7{c[12]}}, c[6:2]};
    ldst_off = {5'b0, c[5], c[12:10], c[6], 2'b00};
    spn_imm  = {2'b0, c[10:7], c[12:11], c[5], c[6], 2'b00};
    sp16_imm = {{3{c[12]}}, c[4:3], c[5], c[2], c[6], 4'b0000};
    lwsp_off = {4'b0, c[3:2], c[12], c[6:4], 2'b00};
    swsp_off = {4'b0, c[8:7], c[12:9], 2'b00};
    joff     = {{10{c[12]}}, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
    boff     = {{5{c[12]}}, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
    res      = rvc_pkg::ILLEGAL_WORD;
    case (c[1:0])
      rvc_pkg::QUAD_0: begin
        case (f3)
          rvc_pkg::C0_ADDI4SPN: begin
            if (spn_imm != '0)
              res = enc_i(spn_imm, rvc_pkg::REG_SP, rvc_pkg::F3_ADD, rdp, rvc_pkg::OP_IMM);
          end
          rvc_pkg::C0_LW: begin
            res = enc_i(ldst_off, rs1p, rvc_pkg::F3_WORD, rdp, rvc_pkg::OP_LOAD);
          end
          rvc_pkg::C0_SW: begin
            res = enc_s(ldst_off, rdp, rs1p, rvc_pkg::F3_WORD, rvc_pkg::OP_STORE);
          end
          default: res = rvc_pkg::ILLEGAL_WORD;
        endcase
      end
      rvc_pkg::QUAD_1: begin
        case (f3)
          rvc_pkg::C1_ADDI: begin
            if (rd == rvc_pkg::REG_ZERO || imm6 == '0) res = rvc_pkg::NOP_WORD;
            else res = enc_i(imm6, rd, rvc_pkg::F3_ADD, rd, rvc_pkg::OP_IMM);
          end
          rvc_pkg::C1_JAL: res = enc_j(joff, rvc_pkg::REG_RA);
          rvc_pkg::C1_LI: begin
            if (rd == rvc_pkg::REG_ZERO) res = rvc_pkg::NOP_WORD;
            else res = enc_i(imm6, rvc_pkg::REG_ZERO, rvc_pkg::F3_ADD, rd, rvc_pkg::OP_IMM);
          end
          rvc_pkg::C1_LUI: begin
            if (rd == rvc_pkg::REG_SP) begin
              if (sp16_imm != '0)
                res = enc_i(sp16_imm, rvc_pkg::REG_SP, rvc_pkg::F3_ADD, rvc_pkg::REG_SP,
                            rvc_pkg::OP_IMM);
            end else if (c[12] == 1'b0 && rs2 == '0) begin
              // zero immediate wins over the rd = 0 hint
              res = rvc_pkg::ILLEGAL_WORD;
            end else if (rd == rvc_pkg::REG_ZERO) begin
              res = rvc_pkg::NOP_WORD;
            end else begin
              res = {{14{c[12]}}, c[12], c[6:2], rd, rvc_pkg::OP_LUI};
            end
          end
          rvc_pkg::C1_MISC: begin
            case (c[11:10])
              rvc_pkg::MISC_SRLI, rvc_pkg::MISC_SRAI: begin
                if (!c[12] && rs2 != '0)
                  res = enc_r(c[10] ? rvc_pkg::F7_ALT : rvc_pkg::F7_BASE, rs2, rs1p,
                              rvc_pkg::F3_SR, rs1p, rvc_pkg::OP_IMM);
              end
              rvc_pkg::MISC_ANDI: begin
                res = enc_i(imm6, rs1p, rvc_pkg::F3_AND, rs1p, rvc_pkg::OP_IMM);
              end
              default: begin
                if (c[12]) begin
                  res = rvc_pkg::NOP_WORD;
                end else begin
                  case (c[6:5])
                    rvc_pkg::RR_SUB: res = enc_r(rvc_pkg::F7_ALT, rdp, rs1p, rvc_pkg::F3_ADD,
                                                 rs1p, rvc_pkg::OP_REG);
                    rvc_pkg::RR_XOR: res = enc_r(rvc_pkg::F7_BASE, rdp, rs1p, rvc_pkg::F3_XOR,
                                                 rs1p, rvc_pkg::OP_REG);
                    rvc_pkg::RR_OR:  res = enc_r(rvc_pkg::F7_BASE, rdp, rs1p, rvc_pkg::F3_OR,
                                                 rs1p, rvc_pkg::OP_REG);
                    default:         res = enc_r(rvc_pkg::F7_BASE, rdp, rs1p, rvc_pkg::F3_AND,
                                                 rs1p, rvc_pkg::OP_REG);
                  endcase
                end
              end
            endcase
          end
          rvc_pkg::C1_J:    res = enc_j(joff, rvc_pkg::REG_ZERO);
          rvc_pkg::C1_BEQZ: res = enc_b(boff, rs1p, rvc_pkg::F3_BEQ);
          default:          res = enc_b(boff, rs1p, rvc_pkg::F3_BNE);
        endcase
      end
      rvc_pkg::QUAD_2: begin
        case (f3)
          rvc_pkg::C2_SLLI: begin
            if (c[12] || rs2 == '0) res = rvc_pkg::ILLEGAL_WORD;
            else if (rd == rvc_pkg::REG_ZERO) res = rvc_pkg::NOP_WORD;
            else res = enc_r(rvc_pkg::F7_BASE, rs2, rd, rvc_pkg::F3_SLL, rd, rvc_pkg::OP_IMM);
          end
          rvc_pkg::C2_LWSP: begin
            if (rd != rvc_pkg::REG_ZERO)
              res = enc_i(lwsp_off, rvc_pkg::REG_SP, rvc_pkg::F3_WORD, rd, rvc_pkg::OP_LOAD);
          end
          rvc_pkg::C2_JRMV: begin
            if (!c[12]) begin
              if (rs2 == rvc_pkg::REG_ZERO) begin
                if (rd != rvc_pkg::REG_ZERO)
                  res = enc_i('0, rd, rvc_pkg::F3_ADD, rvc_pkg::REG_ZERO, rvc_pkg::OP_JALR);
              end else if (rd == rvc_pkg::REG_ZERO) begin
                res = rvc_pkg::NOP_WORD;
              end else begin
                res = enc_r(rvc_pkg::F7_BASE, rs2, rvc_pkg::REG_ZERO, rvc_pkg::F3_ADD, rd,
                            rvc_pkg::OP_REG);
              end
            end else if (rd == rvc_pkg::REG_ZERO && rs2 == rvc_pkg::REG_ZERO) begin
              res = enc_i(rvc_pkg::EBREAK_IMM, rvc_pkg::REG_ZERO, rvc_pkg::F3_ADD,
                          rvc_pkg::REG_ZERO, rvc_pkg::OP_SYS);
            end else if (rs2 == rvc_pkg::REG_ZERO) begin
              res = enc_i('0, rd, rvc_pkg::F3_ADD, rvc_pkg::REG_RA, rvc_pkg::OP_JALR);
            end else if (rd == rvc_pkg::REG_ZERO) begin
              res = rvc_pkg::NOP_WORD;
            end else begin
              res = enc_r(rvc_pkg::F7_BASE, rs2, rd, rvc_pkg::F3_ADD, rd, rvc_pkg::OP_REG);
            end
          end
          rvc_pkg::C2_SWSP: begin
            res = enc_s(swsp_off, rs2, rvc_pkg::REG_SP, rvc_pkg::F3_WORD, rvc_pkg::OP_STORE);
          end
          default: res = rvc_pkg::ILLEGAL_WORD;
        endcase
      end
      default: res = rvc_pkg::ILLEGAL_WORD;
    endcase
    return res;
  endfunction

  // Random compressed word, biased toward real quadrants and zero register fields
  function automatic logic [15:0] rand_cword();
    logic [15:0] w;
    w = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 19) < 17) w[1:0] = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 5) == 0) w[11:7] = rvc_pkg::REG_ZERO;
    if ($urandom_range(0, 5) == 0) w[6:2] = '0;
    if ($urandom_range(0, 9) == 0) w[11:7] = rvc_pkg::REG_SP;
    if ($urandom_range(0, 15) == 0) w[12:5] = '0;
    return w;
  endfunction

  // Driver: offers queued words, holds each beat until taken, idles in bursts
  int unsigned send_gap = 0;
  logic        gaps_on  = 1'b1;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        rvc_pkg::rvc_result_t exp_res;
        exp_res.word    = expand_rvc(compressed_word_i);
        exp_res.illegal = (exp_res.word == rvc_pkg::ILLEGAL_WORD);
        pending_expansions.push_back(exp_res);
        words_sent++;
      end
      if (in_valid_i && !in_ready_o) input_stall_cycles++;
      quiet_tail <= (fetch_words.size() < TailWords);

      if (in_valid_i && !in_ready_o) begin
        // beat still pending: keep valid and payload
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (fetch_words.size() > 0) begin
        if (fetch_words.size() % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        if (!quiet_tail && gaps_on && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 11);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i        <= 1'b1;
          compressed_word_i <= fetch_words.pop_front();
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each result beat, stalls in bursts plus one long hold-off
  int unsigned hold_left      = 0;
  logic        long_hold_done = 1'b0;
  logic        stalls_on      = 1'b1;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rvc_pkg::rvc_result_t exp_res;
        if (pending_expansions.size() == 0) begin
          $error("result beat with nothing expected: expanded_word %h", expanded_word_o);
          mismatch_count++;
        end else begin
          exp_res = pending_expansions.pop_front();
          if (expanded_word_o !== exp_res.word) begin
            $error("expanded_word: expected %h, got %h", exp_res.word, expanded_word_o);
            mismatch_count++;
          end
          if (illegal_flag_o !== exp_res.illegal) begin
            $error("illegal_flag: expected %b, got %b", exp_res.illegal, illegal_flag_o);
            mismatch_count++;
          end
          if (exp_res.illegal) illegal_count++;
          if (exp_res.word == rvc_pkg::NOP_WORD) nop_count++;
        end
        expansions_checked++;
        if (expansions_checked % 64 == 0) stalls_on = ($urandom_range(0, 3) != 0);
      end

      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!long_hold_done && expansions_checked >= 300) begin
        // long hold-off so the pipeline fills and pushes back on the input
        long_hold_done = 1'b1;
        hold_left      = LongHold - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet_tail && stalls_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 11);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // extremes, each instruction, and the hint / reserved / illegal corners
    fetch_words = '{
      16'h0000, 16'hFFFF, 16'h1FFC, 16'h5FFC, 16'hDFFC, 16'h2000,
      16'h0001, 16'h10FD, 16'h3FFD, 16'h507D, 16'h4FFD, 16'h6101,
      16'h717D, 16'h6001, 16'h7005, 16'h7FFD, 16'h9385, 16'h8781,
      16'h847D, 16'h9AD5, 16'h8C01, 16'h8FBD, 16'h8D55, 16'h8EE9,
      16'h9C01, 16'hBFFD, 16'hDFFD, 16'hE001, 16'h0006, 16'h0FFE,
      16'h507E, 16'h5FFE, 16'h8002, 16'h8082, 16'h8006, 16'h8FFE,
      16'h9002, 16'h9082, 16'h9FFE, 16'hDFFE
    };
    n_directed = fetch_words.size();
    repeat (RandomWords) fetch_words.push_back(rand_cword());

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (fetch_words.size() != 0 || in_valid_i || pending_expansions.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d compressed words (%0d directed), checked %0d expansions.",
             words_sent, n_directed, expansions_checked);
    $display("Illegal results %0d, hint NOPs %0d, input backpressure cycles %0d.",
             illegal_count, nop_count, input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rvc_pkg.sv
rtl/core/rvc_expand.sv
rtl/core/rv32c_decompressor.sv
verif/testbench.sv
